### hdl/hqs_pkg.sv
// shared types and constants for the quicksort engine
`timescale 1ns / 1ps

package hqs_pkg;

    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int KEY_W       = 32;
    localparam int STACK_DEPTH = 64;
    localparam int SP_W        = $clog2(STACK_DEPTH);
    localparam int RANGE_W     = 2 * ADDR_W;

    // true when float a < float b, NaN excluded, -0 equals +0
    function automatic logic flt_lt(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
        logic a_zero;
        logic b_zero;
        logic res;
        begin
            a_zero = (a[KEY_W-2:0] == '0);
            b_zero = (b[KEY_W-2:0] == '0);
            if (a_zero && b_zero)
                res = 1'b0;
            else if (a[KEY_W-1] != b[KEY_W-1])
                res = a[KEY_W-1];
            else if (a[KEY_W-1] == 1'b0)
                res = (a[KEY_W-2:0] < b[KEY_W-2:0]);
            else
                res = (a[KEY_W-2:0] > b[KEY_W-2:0]);
            return res;
        end
    endfunction

endpackage

### hdl/hqs_ram.sv
// generic single-port ram with registered read
`timescale 1ns / 1ps

module hqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end

endmodule

### hdl/hoare_quicksort_engine_core.sv
// quicksort engine top level: load, partition sequencer, emit
//
//  channel | dir | fields (low bit first)
//  s_axis  | in  | tdata = key_bits[31:0]; tlast = is_last
//  m_axis  | out | tdata = sorted_bits[31:0]; tuser = overflowed; tlast = end_of_run
//
//  loading writes each accepted item to the key store; the final item starts the sort
//  each partition step uses the key store at one port, one access per cycle,
//  so a swap writes its two keys in turn, first in S_JWT and then in S_SWJ
//  emit steps through S_ERD, S_EWT and S_EOUT for each key into the output register
//  reset clears state, count, drop flag, stack pointer and output valid; the key and range stores need no clearing
//  m_axis stalls hold the emit sequencer; s_axis is blocked while sorting and emitting
`timescale 1ns / 1ps

module hoare_quicksort_engine_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // key_bits
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // sorted_bits
    output logic        m_axis_tuser,   // overflowed
    output logic        m_axis_tlast
);

    localparam int AW = hqs_pkg::ADDR_W;
    localparam int CW = hqs_pkg::CNT_W;
    localparam int KW = hqs_pkg::KEY_W;
    localparam int SW = hqs_pkg::SP_W;
    localparam int RW = hqs_pkg::RANGE_W;

    typedef enum logic [15:0] {
        S_LOAD   = 16'h0001,
        S_START  = 16'h0002,
        S_POP    = 16'h0004,
        S_POPW   = 16'h0008,
        S_PIVR   = 16'h0010,
        S_PIVW   = 16'h0020,
        S_IRD    = 16'h0040,
        S_IWT    = 16'h0080,
        S_JRD    = 16'h0100,
        S_JWT    = 16'h0200,
        S_SWI    = 16'h0400,
        S_SWJ    = 16'h0800,
        S_PUSH   = 16'h1000,
        S_ERD    = 16'h2000,
        S_EWT    = 16'h4000,
        S_EOUT   = 16'h8000
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0] count_reg, count_next;
    logic          drop_reg, drop_next;
    logic [SW:0]   sp_reg, sp_next;
    logic [AW-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [CW:0]   i_reg, i_next, j_reg, j_next;   // signed-ish, offset by 1
    logic [KW-1:0] piv_reg, piv_next, ival_reg, ival_next;
    logic [AW-1:0] ek_reg, ek_next;
    logic          pushr_reg, pushr_next;
    logic          ov_reg, ov_next, vld_reg, vld_next, last_reg, last_next;
    logic [KW-1:0] dat_reg, dat_next;

    logic          k_we;
    logic [AW-1:0] k_addr;
    logic [KW-1:0] k_wdata, k_rdata;
    logic          r_we;
    logic [SW-1:0] r_addr;
    logic [RW-1:0] r_wdata, r_rdata;

    hqs_ram #(.WIDTH(KW), .DEPTH(hqs_pkg::STORE_DEPTH)) u_keys (
        .clk(clk), .we(k_we), .addr(k_addr), .wdata(k_wdata), .rdata(k_rdata)
    );

    hqs_ram #(.WIDTH(RW), .DEPTH(hqs_pkg::STACK_DEPTH)) u_ranges (
        .clk(clk), .we(r_we), .addr(r_addr), .wdata(r_wdata), .rdata(r_rdata)
    );

    // i and j carry +1 offset so j can reach lo-1 without going negative
    logic [AW-1:0] ia, ja;
    logic [CW:0]   lo_e, hi_e;
    assign ia   = AW'(i_reg - 1'b1);
    assign ja   = AW'(j_reg - 1'b1);
    assign lo_e = (CW+1)'(lo_reg) + 1'b1;
    assign hi_e = (CW+1)'(hi_reg) + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            count_reg <= '0;
            drop_reg  <= 1'b0;
            sp_reg    <= '0;
            vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            drop_reg  <= drop_next;
            sp_reg    <= sp_next;
            vld_reg   <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        piv_reg   <= piv_next;
        ival_reg  <= ival_next;
        ek_reg    <= ek_next;
        pushr_reg <= pushr_next;
        ov_reg    <= ov_next;
        last_reg  <= last_next;
        dat_reg   <= dat_next;
    end

    assign s_axis_tready = (state_reg == S_LOAD);
    assign m_axis_tvalid = vld_reg;
    assign m_axis_tdata  = dat_reg;
    assign m_axis_tuser  = ov_reg;
    assign m_axis_tlast  = last_reg;

    always_comb
    begin
        logic [CW-1:0] n;
        logic          push_r, push_l;
        n          = count_reg;
        push_r     = 1'b0;
        push_l     = 1'b0;
        state_next = state_reg;
        count_next = count_reg;
        drop_next  = drop_reg;
        sp_next    = sp_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        piv_next   = piv_reg;
        ival_next  = ival_reg;
        ek_next    = ek_reg;
        pushr_next = pushr_reg;
        ov_next    = ov_reg;
        last_next  = last_reg;
        dat_next   = dat_reg;
        vld_next   = vld_reg;
        k_we       = 1'b0;
        k_addr     = ia;
        k_wdata    = s_axis_tdata;
        r_we       = 1'b0;
        r_addr     = SW'(sp_reg);
        r_wdata    = {lo_reg, AW'(hi_e - 1'b1)};

        if (vld_reg && m_axis_tready)
            vld_next = 1'b0;

        unique case (state_reg)
            S_LOAD:
            begin
                k_addr = AW'(count_reg);
                if (s_axis_tvalid)
                begin
                    if (count_reg < CW'(hqs_pkg::STORE_DEPTH))
                    begin
                        k_we       = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    else
                        drop_next = 1'b1;
                    if (s_axis_tlast)
                        state_next = S_START;
                end
            end
            S_START:
            begin
                sp_next = '0;
                ek_next = '0;
                if (count_reg >= CW'(2))
                begin
                    r_we    = 1'b1;
                    r_addr  = '0;
                    r_wdata = {AW'(0), AW'(count_reg - 1'b1)};
                    sp_next = (SW+1)'(1);
                    state_next = S_POP;
                end
                else
                    state_next = S_ERD;
            end
            S_POP:
            begin
                if (sp_reg == '0)
                    state_next = S_ERD;
                else
                begin
                    r_addr     = SW'(sp_reg - 1'b1);
                    sp_next    = sp_reg - 1'b1;
                    state_next = S_POPW;
                end
            end
            S_POPW:
            begin
                lo_next    = r_rdata[RW-1:AW];
                hi_next    = r_rdata[AW-1:0];
                state_next = S_PIVR;
            end
            S_PIVR:
            begin
                k_addr     = AW'(({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1);
                i_next     = lo_e;
                j_next     = hi_e;
                state_next = S_PIVW;
            end
            S_PIVW:
            begin
                piv_next   = k_rdata;
                state_next = S_IRD;
            end
            S_IRD:
            begin
                k_addr     = ia;
                state_next = S_IWT;
            end
            S_IWT:
            begin
                ival_next = k_rdata;
                if (i_reg < hi_e && hqs_pkg::flt_lt(k_rdata, piv_reg))
                begin
                    i_next     = i_reg + 1'b1;
                    k_addr     = AW'(i_reg);
                    state_next = S_IWT;
                end
                else
                begin
                    k_addr     = ja;
                    state_next = S_JWT;
                end
            end
            S_JRD:
                state_next = state_reg;
            S_JWT:
            begin
                if (j_reg > lo_e && hqs_pkg::flt_lt(piv_reg, k_rdata))
                begin
                    j_next     = j_reg - 1'b1;
                    k_addr     = AW'(j_reg - 2'd2);
                    state_next = S_JWT;
                end
                else if (i_reg <= j_reg)
                begin
                    // write ith slot with jth key
                    k_we       = 1'b1;
                    k_addr     = ia;
                    k_wdata    = k_rdata;
                    state_next = S_SWJ;
                end
                else
                    state_next = S_PUSH;
            end
            S_SWJ:
            begin
                k_we    = 1'b1;
                k_addr  = ja;
                k_wdata = ival_reg;
                i_next  = i_reg + 1'b1;
                j_next  = j_reg - 1'b1;
                if ((i_reg + 1'b1) < (j_reg - 1'b1))
                    state_next = S_IRD;
                else
                    state_next = S_PUSH;
            end
            S_SWI:
                state_next = S_PUSH;
            S_PUSH:
            begin
                push_r = (i_reg < hi_e) && !pushr_reg;
                push_l = (lo_e < j_reg);
                if (push_r)
                begin
                    r_we       = 1'b1;
                    r_addr     = SW'(sp_reg);
                    r_wdata    = {AW'(i_reg - 1'b1), hi_reg};
                    sp_next    = sp_reg + 1'b1;
                    pushr_next = 1'b1;
                end
                else
                begin
                    if (push_l)
                    begin
                        r_we    = 1'b1;
                        r_addr  = SW'(sp_reg);
                        r_wdata = {lo_reg, AW'(j_reg - 1'b1)};
                        sp_next = sp_reg + 1'b1;
                    end
                    pushr_next = 1'b0;
                    state_next = S_POP;
                end
            end
            S_ERD:
            begin
                k_addr     = ek_reg;
                state_next = S_EWT;
            end
            S_EWT:
            begin
                k_addr     = ek_reg;
                state_next = S_EOUT;
            end
            S_EOUT:
            begin
                k_addr = ek_reg;
                if (!vld_reg || m_axis_tready)
                begin
                    vld_next  = 1'b1;
                    dat_next  = k_rdata;
                    ov_next   = drop_reg;
                    last_next = ((CW)'(ek_reg) + 1'b1 == n);
                    if ((CW)'(ek_reg) + 1'b1 == n)
                    begin
                        count_next = '0;
                        drop_next  = 1'b0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        ek_next    = ek_reg + 1'b1;
                        state_next = S_ERD;
                    end
                end
            end
            default:
                state_next = S_LOAD;
        endcase

        // empty set: nothing to emit, return to loading
        if (state_reg == S_START && count_reg == '0)
        begin
            drop_next  = 1'b0;
            state_next = S_LOAD;
        end
        if (state_reg == S_START)
            pushr_next = 1'b0;
    end

endmodule
